// ----- rtl/lfsa_pkg.sv -----
// shared constants, status codes and helpers for the lowest free slot allocator
// no dependencies; imported by lfsa_lowest and the top level module of the block
package lfsa_pkg;

    localparam int SLOTS   = 64;
    localparam int GUESTS  = 256;
    localparam int SLOT_W  = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int GIDX_W  = (GUESTS > 2) ? $clog2(GUESTS) : 1;
    localparam int FIELD_W = 6;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_SEATED     = 2'd2,
        ST_NOT_SEATED = 2'd3
    } status_t;

    typedef enum logic {
        FN_ARRIVE = 1'b0,
        FN_LEAVE  = 1'b1
    } func_t;

    // guest table row: guest id modulo table depth
    function automatic logic [GIDX_W-1:0] guest_index(input logic [7:0] id);
        logic [31:0] wide;
        begin
            wide = 32'(id) % GUESTS;
            return wide[GIDX_W-1:0];
        end
    endfunction

    // slot number cut or widened to the 6-bit result field
    function automatic logic [FIELD_W-1:0] to_field(input logic [SLOT_W-1:0] s);
        logic [31:0] wide;
        begin
            wide = 32'(s);
            return wide[FIELD_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/lfsa_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module lfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lfsa_lowest.sv -----
// priority encoder: index of the lowest set bit of the slot map
// depends on lfsa_pkg
module lfsa_lowest
    import lfsa_pkg::*;
(
    input  logic [SLOTS-1:0]  map,
    output logic [SLOT_W-1:0] idx,
    output logic              found
);

    logic [SLOTS-1:0] onehot;

    // isolate the lowest set bit
    assign onehot = map & (~map + SLOTS'(1));
    assign found  = |map;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | SLOT_W'(i);
            end
        end
    end

endmodule

// ----- rtl/lowest_free_slot_allocator.sv -----
// top level of the lowest free slot allocator: input stage, decision logic, result register
// depends on lfsa_pkg, lfsa_ram, lfsa_lowest
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------
// in       | to block  | in_valid / in_stall  | func, guest_id
// out      | from block| out_valid / out_stall| slot, status, lowest_free, all_taken
//
// one word per clock sustained while the result is not stalled; a word taken passes
// through the input stage, then the result register
// the rate is set by the single decision stage: at most one seat table write and one
// free map update per word, with a forward path around the registered seat table read
// reset marks every slot free and clears the seated flags at once; no clearing pass
// a stalled result holds the decision stage, and in_stall rises only when that
// stage is full and cannot move on
module lowest_free_slot_allocator
    import lfsa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         guest_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FIELD_W-1:0] slot,
    output logic [1:0]         status,
    output logic [FIELD_W-1:0] lowest_free,
    output logic               all_taken
);

    // allocator state
    logic [SLOTS-1:0]  free_map_reg;
    logic [SLOTS-1:0]  free_map_next;
    logic [GUESTS-1:0] seated_reg;
    logic [GUESTS-1:0] seated_next;

    // decision stage
    logic              s1_valid_reg;
    func_t             s1_func_reg;
    logic [GIDX_W-1:0] s1_gidx_reg;
    logic              s1_fwd_hit_reg;
    logic [SLOT_W-1:0] s1_fwd_seat_reg;

    // result register
    logic               out_valid_reg;
    logic [FIELD_W-1:0] slot_reg;
    status_t            status_reg;
    logic [FIELD_W-1:0] lowest_free_reg;
    logic               all_taken_reg;

    // handshakes
    logic              in_take;
    logic              s1_advance;
    logic [GIDX_W-1:0] in_gidx;

    // seat table port signals
    logic              ram_we;
    logic [SLOT_W-1:0] ram_rdata;
    logic [SLOT_W-1:0] seat_cur;

    // lowest free slot now, and the one after it
    logic [SLOT_W-1:0] low_idx;
    logic              low_found;
    logic [SLOT_W-1:0] second_idx;
    logic              second_found;

    // decision results
    status_t           st_c;
    logic [SLOT_W-1:0] slot_c;
    logic [SLOT_W-1:0] after_idx_c;
    logic              after_none_c;
    logic              arrive_ok;
    logic              leave_ok;
    logic              seated_cur;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_take    = in_valid && !in_stall;
    assign in_gidx    = guest_index(guest_id);

    // only a seating writes the seat table
    assign ram_we = s1_advance && arrive_ok;

    lfsa_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(GUESTS)
    ) u_seat_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(s1_gidx_reg),
        .wdata(low_idx),
        .re   (in_take),
        .raddr(in_gidx),
        .rdata(ram_rdata)
    );

    lfsa_lowest u_low (
        .map  (free_map_reg),
        .idx  (low_idx),
        .found(low_found)
    );

    // map with the lowest free bit cleared gives the lowest free after a seating
    lfsa_lowest u_second (
        .map  (free_map_reg & (free_map_reg - SLOTS'(1))),
        .idx  (second_idx),
        .found(second_found)
    );

    // table read taken on the same edge as the previous word's write sees old data
    assign seat_cur   = s1_fwd_hit_reg ? s1_fwd_seat_reg : ram_rdata;
    assign seated_cur = seated_reg[s1_gidx_reg];

    always_comb
    begin
        st_c         = ST_OK;
        slot_c       = '0;
        after_idx_c  = low_idx;
        after_none_c = !low_found;
        arrive_ok    = 1'b0;
        leave_ok     = 1'b0;
        case (s1_func_reg)
            FN_ARRIVE:
            begin
                if (seated_cur)
                begin
                    st_c = ST_SEATED;
                end
                else if (!low_found)
                begin
                    st_c = ST_NO_FREE;
                end
                else
                begin
                    arrive_ok    = 1'b1;
                    slot_c       = low_idx;
                    after_idx_c  = second_idx;
                    after_none_c = !second_found;
                end
            end
            FN_LEAVE:
            begin
                if (!seated_cur)
                begin
                    st_c = ST_NOT_SEATED;
                end
                else
                begin
                    leave_ok     = 1'b1;
                    slot_c       = seat_cur;
                    after_none_c = 1'b0;
                    if (!low_found || (seat_cur < low_idx))
                    begin
                        after_idx_c = seat_cur;
                    end
                end
            end
            default:
            begin
                st_c = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        free_map_next = free_map_reg;
        seated_next   = seated_reg;
        if (s1_advance && arrive_ok)
        begin
            free_map_next[low_idx]   = 1'b0;
            seated_next[s1_gidx_reg] = 1'b1;
        end
        else if (s1_advance && leave_ok)
        begin
            free_map_next[seat_cur]  = 1'b1;
            seated_next[s1_gidx_reg] = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_map_reg  <= '1;
            seated_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_map_reg <= free_map_next;
            seated_reg   <= seated_next;
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg     <= func_t'(func);
            s1_gidx_reg     <= in_gidx;
            s1_fwd_hit_reg  <= ram_we && (s1_gidx_reg == in_gidx);
            s1_fwd_seat_reg <= low_idx;
        end
        if (s1_advance)
        begin
            slot_reg        <= to_field(slot_c);
            status_reg      <= st_c;
            lowest_free_reg <= after_none_c ? '0 : to_field(after_idx_c);
            all_taken_reg   <= after_none_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot        = slot_reg;
    assign status      = status_reg;
    assign lowest_free = lowest_free_reg;
    assign all_taken   = all_taken_reg;

    // a seating takes its slot out of the free map
    a_arrive_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && arrive_ok) |=> !free_map_reg[$past(low_idx)])
        else $error("seated slot still marked free");

    // a seating marks the guest seated
    a_arrive_seats: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && arrive_ok) |=> seated_reg[$past(s1_gidx_reg)])
        else $error("guest not marked seated after arrive");

    // a leave returns its slot to the free map
    a_leave_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && leave_ok) |=> free_map_reg[$past(seat_cur)])
        else $error("freed slot not marked free");

    // a full map reports slot zero as lowest free
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && all_taken_reg) |-> (lowest_free_reg == '0))
        else $error("lowest free not zero with every slot taken");

    // the input side is held back only by a full decision stage
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

// ----- verif/tb_lowest_free_slot_allocator.sv -----
// self-checking testbench for the lowest free slot allocator: arrive and leave words
// under four idling phases, every result checked against an in-bench seating model
// depends on rtl/lfsa_pkg.sv and rtl/lowest_free_slot_allocator.sv
`timescale 1ns / 1ps

module tb_lowest_free_slot_allocator;
    import lfsa_pkg::*;

    // run limit in clock cycles, far above the slowest legal run (~815 words, with
    // 81 percent sender gaps in one phase and receiver stalls in another)
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;

    // one arrive or leave word as the sender holds it
    typedef struct {
        func_t      kind;
        logic [7:0] guest;
    } guest_move_t;

    // one expected result word
    typedef struct packed {
        logic [FIELD_W-1:0] slot;
        status_t            status;
        logic [FIELD_W-1:0] lowest_free;
        logic               all_taken;
    } seating_t;

    // dut ports, the driven ones all known from time zero
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               func      = FN_ARRIVE;
    logic [7:0]         guest_id  = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [FIELD_W-1:0] slot;
    logic [1:0]         status;
    logic [FIELD_W-1:0] lowest_free;
    logic               all_taken;

    // seating model: free slot map, seat table and seated flags
    logic [SLOTS-1:0]   free_slots = '1;
    logic [SLOT_W-1:0]  seat_of [GUESTS];
    logic               seated  [GUESTS];

    // stimulus-side view of who is seated, used only to shape the random words
    logic               gen_seated [GUESTS];
    int                 gen_count = 0;

    guest_move_t        pending_moves_q [$];
    seating_t           expected_seatings_q [$];

    // idling knobs, changed by the stimulus block on falling edges only
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int failures       = 0;
    int reported       = 0;
    int words_in       = 0;
    int words_out      = 0;
    int refused_full   = 0;
    int all_taken_seen = 0;
    int cycles         = 0;

    int fill_plan [4]  = '{95, 60, 95, 10};
    int phase_send [4] = '{0, 81, 0, 14};
    int phase_recv [4] = '{0, 0, 81, 14};

    lowest_free_slot_allocator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .guest_id    (guest_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot        (slot),
        .status      (status),
        .lowest_free (lowest_free),
        .all_taken   (all_taken)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // priority search over the model's free map; SLOTS when nothing is free
    function automatic int first_free_slot();
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            if (free_slots[i])
                return i;
        end
        return SLOTS;
    endfunction

    // apply one word to the seating model and return the result it should produce
    function automatic seating_t predict_seating(input func_t kind, input logic [7:0] guest);
        seating_t res;
        int       g;
        int       f;
        int       s;
        int       low;
        g          = int'(guest) % GUESTS;
        res.slot   = '0;
        res.status = ST_OK;
        if (kind == FN_ARRIVE)
        begin
            // a seated guest is refused before the map is even looked at
            if (seated[g])
                res.status = ST_SEATED;
            else
            begin
                f = first_free_slot();
                if (f >= SLOTS)
                    res.status = ST_NO_FREE;
                else
                begin
                    free_slots[f] = 1'b0;
                    seat_of[g]    = f[SLOT_W-1:0];
                    seated[g]     = 1'b1;
                    res.slot      = f[FIELD_W-1:0];
                end
            end
        end
        else
        begin
            if (!seated[g])
                res.status = ST_NOT_SEATED;
            else
            begin
                s             = int'(seat_of[g]);
                free_slots[s] = 1'b1;
                seated[g]     = 1'b0;
                res.slot      = s[FIELD_W-1:0];
            end
        end
        // map state after the step, errors included
        low = first_free_slot();
        if (low >= SLOTS)
        begin
            res.lowest_free = '0;
            res.all_taken   = 1'b1;
        end
        else
        begin
            res.lowest_free = low[FIELD_W-1:0];
            res.all_taken   = 1'b0;
        end
        return res;
    endfunction

    // queue one word and keep the stimulus-side seating view in step
    task automatic push_move(input func_t kind, input logic [7:0] guest);
        int          g;
        guest_move_t mv;
        g = int'(guest) % GUESTS;
        if (kind == FN_ARRIVE && !gen_seated[g] && gen_count < SLOTS)
        begin
            gen_seated[g] = 1'b1;
            gen_count++;
        end
        else if (kind == FN_LEAVE && gen_seated[g])
        begin
            gen_seated[g] = 1'b0;
            gen_count--;
        end
        mv.kind  = kind;
        mv.guest = guest;
        pending_moves_q.insert(pending_moves_q.size(), mv);
    endtask

    // random words: mostly legal arrives of unseated guests and leaves of seated
    // ones, with the arrive share swept per segment so the map fills up, runs
    // full and empties again; the rest is unconstrained noise
    task automatic queue_moves(input int count);
        int i;
        int g;
        int arrive_pct;
        arrive_pct = fill_plan[0];
        for (i = 0; i < count; i++)
        begin
            if (i % 48 == 0)
                arrive_pct = fill_plan[(i / 48) % 4];
            if ($urandom_range(99) < 15)
                push_move(func_t'($urandom_range(1)), 8'($urandom_range(255)));
            else if ($urandom_range(99) < arrive_pct || gen_count == 0)
            begin
                // arrive of an unseated guest; refused when the map is full
                do
                    g = $urandom_range(255);
                while (gen_seated[g % GUESTS]);
                push_move(FN_ARRIVE, 8'(g));
            end
            else
            begin
                // leave of a guest who holds a slot
                do
                    g = $urandom_range(255);
                while (!gen_seated[g % GUESTS]);
                push_move(FN_LEAVE, 8'(g));
            end
        end
    endtask

    // wait on falling edges until the sender holds nothing and no result is owed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_moves_q.size() != 0 || in_valid || expected_seatings_q.size() != 0);
    endtask

    // driver: a new word is offered only when none is held or the held one is
    // taken at this edge, so a stalled word never changes; acceptance feeds
    // the seating model in arrival order
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        guest_move_t mv;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= FN_ARRIVE;
            guest_id <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_seatings_q.insert(expected_seatings_q.size(),
                                           predict_seating(func_t'(func), guest_id));
                words_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_moves_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    mv = pending_moves_q.pop_front();
                    in_valid <= 1'b1;
                    func     <= mv.kind;
                    guest_id <= mv.guest;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: every taken result word is matched against the oldest expectation;
    // the stall is rolled each cycle whether or not a word is offered
    always @(posedge clk or negedge rst_n)
    begin : check_results
        seating_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                words_out++;
                if (expected_seatings_q.size() == 0)
                begin
                    failures++;
                    if (reported < MAX_REPORTS)
                    begin
                        reported++;
                        $display("unexpected result word: slot %0d status %0d lowest %0d full %0d",
                                 slot, status, lowest_free, all_taken);
                    end
                end
                else
                begin
                    want = expected_seatings_q.pop_front();
                    if (want.status == ST_NO_FREE)
                        refused_full++;
                    if (want.all_taken)
                        all_taken_seen++;
                    if (slot !== want.slot || status !== want.status
                        || lowest_free !== want.lowest_free || all_taken !== want.all_taken)
                    begin
                        failures++;
                        if (reported < MAX_REPORTS)
                        begin
                            reported++;
                            $display("mismatch on result %0d: expected slot %0d status %0d %s",
                                     words_out, want.slot, want.status, "");
                            $display("    expected lowest %0d full %0d",
                                     want.lowest_free, want.all_taken);
                            $display("    got slot %0d status %0d lowest %0d full %0d",
                                     slot, status, lowest_free, all_taken);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, expected_seatings_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus and phase control
    initial
    begin : run_phases
        int p;
        int g;
        for (g = 0; g < GUESTS; g++)
        begin
            seated[g]     = 1'b0;
            gen_seated[g] = 1'b0;
            seat_of[g]    = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening: lowest slot handout, reuse of a freed slot, both id
        // extremes, arrive of a seated guest, leave of an unseated guest and a
        // double leave; ends with an empty map
        push_move(FN_ARRIVE, 8'd0);
        push_move(FN_ARRIVE, 8'd255);
        push_move(FN_ARRIVE, 8'd0);
        push_move(FN_LEAVE,  8'd128);
        push_move(FN_LEAVE,  8'd0);
        push_move(FN_ARRIVE, 8'd170);
        push_move(FN_ARRIVE, 8'd85);
        push_move(FN_LEAVE,  8'd255);
        push_move(FN_LEAVE,  8'd255);
        push_move(FN_ARRIVE, 8'd1);
        push_move(FN_LEAVE,  8'd170);
        push_move(FN_LEAVE,  8'd85);
        push_move(FN_LEAVE,  8'd1);

        // no idling, sender gaps, receiver stalls, then both lightly
        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            queue_moves(200);
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_seatings_q.size() != 0)
        begin
            failures++;
            $display("%0d expected results never arrived", expected_seatings_q.size());
        end

        $display("%0d arrive/leave words sent, %0d results checked over four idling phases",
                 words_in, words_out);
        $display("%0d arrivals turned away on a full map, %0d results with every slot taken",
                 refused_full, all_taken_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
